// ===== rtl/core/wfgdd_pkg.sv =====
package wfgdd_pkg;

    // agent ids are the 4-bit id fields; the table holds one entry per agent
    localparam int AGENTS = 16;
    localparam int ID_W   = 4;
    localparam int OP_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_TEST   = 3'd2,
        OP_CHECK  = 3'd3,
        OP_PATH   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_HEAD,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] waiter_id;
        logic [ID_W-1:0] holder_id;
    } cmd_t;

    typedef struct packed {
        logic            cycle_found;
        logic [ID_W-1:0] path_agent;
        logic            is_last;
    } res_t;

endpackage

// ===== rtl/core/wait_for_graph_deadlock_detector_top.sv =====
// one item at a time: a beat is taken in idle and decoded the next cycle; add and remove end there
// test and check then walk the holder chain element by element until it closes or ends
// path sends a head beat, then one beat per chain element
// results leave through an output register; a stalled output holds the walk
// reset: asynchronous active low, clears all edges and the control state; holder
// entries are undefined until added
module wait_for_graph_deadlock_detector_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // op[2:0], waiter_id[6:3], holder_id[10:7], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // cycle_found[0], path_agent[4:1], zero fill
    output logic        m_axis_tlast    // is_last
);
    import wfgdd_pkg::*;

    cmd_t cmd_w;
    res_t res_w;
    logic res_valid_w;
    logic res_ready_w;

    logic            m_valid_reg;
    logic            m_cycle_reg;
    logic [ID_W-1:0] m_agent_reg;
    logic            m_last_reg;

    // unpack the input beat
    assign cmd_w.op        = s_axis_tdata[OP_W-1:0];
    assign cmd_w.waiter_id = s_axis_tdata[OP_W+ID_W-1:OP_W];
    assign cmd_w.holder_id = s_axis_tdata[OP_W+2*ID_W-1:OP_W+ID_W];

    // table, visited marks and the chain walker
    wfgdd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd       (cmd_w),
        .cmd_ready (s_axis_tready),
        .res_valid (res_valid_w),
        .res       (res_w),
        .res_ready (res_ready_w)
    );

    // output register: the walker is held while a waiting beat is not taken
    assign res_ready_w = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready_w)
        begin
            m_valid_reg <= res_valid_w;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (res_ready_w && res_valid_w)
        begin
            m_cycle_reg <= res_w.cycle_found;
            m_agent_reg <= res_w.path_agent;
            m_last_reg  <= res_w.is_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_agent_reg, m_cycle_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== rtl/core/wfgdd_engine.sv =====
module wfgdd_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  wfgdd_pkg::cmd_t   cmd,
    output logic              cmd_ready,
    output logic              res_valid,
    output wfgdd_pkg::res_t   res,
    input  logic              res_ready
);
    import wfgdd_pkg::*;

    state_t state_reg, state_next;

    cmd_t            cmd_reg;
    logic [ID_W-1:0] cur_reg;
    logic            first_reg;
    logic            cyc_reg;

    // holder table, one synchronous read port
    logic [ID_W-1:0] table_mem [AGENTS];
    logic [ID_W-1:0] rd_data_reg;

    logic [AGENTS-1:0] edge_valid_reg;
    logic [AGENTS-1:0] visited_reg;

    // control strobes
    logic            take_cmd;
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic            wr_en;
    logic            clr_edge;
    logic            clr_visited;
    logic            advance;
    logic            load_cur;
    logic [ID_W-1:0] cur_load_val;
    logic            load_cyc;
    logic            cyc_load_val;

    logic [ID_W-1:0] cur_w;
    logic            hit;
    logic            stop;
    op_t             op_w;

    assign op_w  = op_t'(cmd_reg.op);
    // test and path take the first link from a register, other links come from the table read register
    assign cur_w = first_reg ? cur_reg : rd_data_reg;
    assign hit   = (cur_w == cmd_reg.waiter_id);
    assign stop  = hit || visited_reg[cur_w] || !edge_valid_reg[cur_w];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                case (op_w)
                    OP_TEST:
                    begin
                        if (cmd_reg.waiter_id == cmd_reg.holder_id)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    OP_CHECK:
                    begin
                        if (edge_valid_reg[cmd_reg.waiter_id])
                        begin
                            state_next = ST_WALK;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_PATH:  state_next = ST_HEAD;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_HEAD:
            begin
                if (res_ready)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stop && res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb
    begin
        cmd_ready    = 1'b0;
        take_cmd     = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        rd_en        = 1'b0;
        rd_addr      = cur_w;
        wr_en        = 1'b0;
        clr_edge     = 1'b0;
        clr_visited  = 1'b0;
        advance      = 1'b0;
        load_cur     = 1'b0;
        cur_load_val = cmd_reg.holder_id;
        load_cyc     = 1'b0;
        cyc_load_val = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                take_cmd  = cmd_valid;
            end
            ST_START:
            begin
                clr_visited = 1'b1;
                case (op_w)
                    OP_ADD:    wr_en    = 1'b1;
                    OP_REMOVE: clr_edge = 1'b1;
                    OP_TEST:
                    begin
                        load_cur     = 1'b1;
                        load_cyc     = 1'b1;
                        cyc_load_val = 1'b1;
                    end
                    OP_CHECK:
                    begin
                        // fetch the waiter's holder, walk starts there
                        rd_en    = 1'b1;
                        rd_addr  = cmd_reg.waiter_id;
                        load_cyc = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_HEAD:
            begin
                res_valid       = 1'b1;
                res.path_agent  = cmd_reg.waiter_id;
                if (res_ready)
                begin
                    load_cur = 1'b1;
                end
            end
            ST_WALK:
            begin
                if (op_w == OP_PATH)
                begin
                    res_valid      = 1'b1;
                    res.path_agent = cur_w;
                    res.is_last    = stop;
                    if (res_ready && !stop)
                    begin
                        advance = 1'b1;
                    end
                end
                else if (stop)
                begin
                    res_valid       = 1'b1;
                    res.cycle_found = hit;
                    res.is_last     = 1'b1;
                end
                else
                begin
                    advance = 1'b1;
                end
                rd_en = advance;
            end
            ST_DONE:
            begin
                res_valid       = 1'b1;
                res.cycle_found = cyc_reg;
                res.is_last     = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_valid_reg <= '0;
            visited_reg    <= '0;
            first_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                edge_valid_reg[cmd_reg.waiter_id] <= 1'b1;
            end
            if (clr_edge)
            begin
                edge_valid_reg[cmd_reg.waiter_id] <= 1'b0;
            end
            if (clr_visited)
            begin
                visited_reg <= '0;
            end
            else if (advance)
            begin
                visited_reg[cur_w] <= 1'b1;
            end
            if (load_cur)
            begin
                first_reg <= 1'b1;
            end
            else if (advance || (state_reg == ST_START))
            begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            cmd_reg <= cmd;
        end
        if (load_cur)
        begin
            cur_reg <= cur_load_val;
        end
        if (load_cyc)
        begin
            cyc_reg <= cyc_load_val;
        end
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[cmd_reg.waiter_id] <= cmd_reg.holder_id;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

endmodule
